// ===== src/sasc_pkg.sv =====
// Package with types, codes and helpers shared by the score cache modules.
`timescale 1ns / 1ps
package sasc_pkg;

  localparam int KEY_W = 64;
  localparam int TAG_W = 16;
  localparam int TAG_SHIFT = 48;
  localparam int CFG_W = 17;
  localparam int CFG_ADDR_W = 2;

  localparam int DEFAULT_WAYS = 4;
  localparam int DEFAULT_MAX_BUCKETS = 65536;

  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] BND_LOWER = 2'd1;
  localparam logic [1:0] BND_UPPER = 2'd2;
  localparam logic [1:0] BND_EXACT = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GENERATION = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MATE_SCORE = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PLY = 2'd3;

  localparam logic [16:0] RST_BUCKET_COUNT = 17'd0;
  localparam logic [7:0] RST_GENERATION = 8'd0;
  localparam logic [14:0] RST_MATE_SCORE = 15'd32000;
  localparam logic [7:0] RST_MAX_PLY = 8'd128;

  typedef struct packed {
    logic [1:0] kind;
    logic [63:0] key;
    logic signed [7:0] req_depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [7:0] ply;
    logic signed [15:0] new_score;
    logic [1:0] new_bound;
    logic [15:0] new_move;
  } in_word_t;

  typedef struct packed {
    logic hit;
    logic [15:0] hit_tag;
    logic signed [7:0] hit_depth;
    logic signed [15:0] hit_score;
    logic [1:0] hit_bound;
    logic [15:0] hit_move;
    logic [7:0] hit_age;
  } out_word_t;

  typedef struct packed {
    logic [15:0] tag;
    logic signed [7:0] depth;
    logic signed [15:0] score;
    logic [1:0] bound;
    logic [7:0] age;
    logic [15:0] move;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic mem_read;
    logic scan_init;
    logic scan_step;
    logic mem_write;
    logic sweep_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_stop;
    logic sweep_last;
    logic n_zero;
    logic [1:0] kind;
  } status_t;

  // Mate scores move away from or toward zero by the ply distance.
  function automatic logic signed [17:0] shift_mate(input logic signed [15:0] s,
      input logic [7:0] ply, input logic [14:0] mate, input logic [7:0] mply,
      input logic storing);
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    logic signed [17:0] se;
    logic signed [17:0] pe;
    hi = $signed({3'b000, mate}) - $signed({10'd0, mply});
    lo = -hi;
    se = {{2{s[15]}}, s};
    pe = $signed({10'd0, ply});
    if (se >= hi) begin
      return storing ? se + pe : se - pe;
    end else if (se <= lo) begin
      return storing ? se - pe : se + pe;
    end
    return se;
  endfunction

endpackage

// ===== src/set_assoc_score_cache.sv =====
// Top level of the set-associative search score cache.
// A word passes through the key remainder, one row read, a scan of up to WAYS ways and a
// result load; a store adds a row write. With a bucket count of zero, words other than a clear
// go straight to the result. A clear word zeroes all MAX_BUCKETS rows, one row per cycle,
// whatever the bucket count. One word is in flight at a time; the next is taken from the cycle
// in which a result appears, even while that result waits.
// Reset is synchronous; afterwards a clearing pass over all MAX_BUCKETS rows runs with in_ready low.
`timescale 1ns / 1ps
module set_assoc_score_cache import sasc_pkg::*; #(
  parameter int WAYS = DEFAULT_WAYS,
  parameter int MAX_BUCKETS = DEFAULT_MAX_BUCKETS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cmd_t    cmd;
  status_t st;

  sasc_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_kind(in_data.kind),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st(st),
    .cmd(cmd)
  );

  sasc_datapath #(.WAYS(WAYS), .MAX_BUCKETS(MAX_BUCKETS)) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_data(in_data),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd),
    .st(st)
  );

endmodule

// ===== src/sasc_divider.sv =====
// Bit-serial remainder unit for the 64-bit key modulo the bucket count.
`timescale 1ns / 1ps
module sasc_divider import sasc_pkg::*; #(
  parameter int NW = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [NW-1:0]    divisor,
  output logic             done,
  output logic [NW-1:0]    rem
);

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic [NW:0]      rem_r;
  logic [KEY_W-1:0] key_r;
  logic [NW:0]      trial;

  always_comb begin
    trial = {rem_r[NW-1:0], key_r[KEY_W-1]};
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      key_r <= dividend;
    end else if (busy_r) begin
      rem_r <= trial;
      key_r <= {key_r[KEY_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem = rem_r[NW-1:0];

endmodule

// ===== src/sasc_ctrl.sv =====
// Controller state machine that sequences clearing, remainder, read, scan and write.
`timescale 1ns / 1ps
module sasc_ctrl import sasc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    st,
  output cmd_t       cmd
);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_SWP = 3'd6;
  localparam logic [2:0] S_FIN = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.sweep_en = 1'b1;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          if (in_kind == KIND_CLEAR) begin
            state_nxt = S_SWP;
          end else if (st.n_zero) begin
            state_nxt = S_FIN;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (st.div_done) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_stop) state_nxt = (st.kind == KIND_STORE) ? S_WRITE : S_FIN;
      end
      S_WRITE: begin
        cmd.mem_write = 1'b1;
        state_nxt = S_FIN;
      end
      S_SWP: begin
        cmd.sweep_en = 1'b1;
        if (st.sweep_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/sasc_datapath.sv =====
// Datapath with configuration registers, bucket memory, way scan and result register.
`timescale 1ns / 1ps
module sasc_datapath import sasc_pkg::*; #(
  parameter int WAYS = DEFAULT_WAYS,
  parameter int MAX_BUCKETS = DEFAULT_MAX_BUCKETS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_word_t              in_data,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  cmd_t                  cmd,
  output status_t               st
);

  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef entry_t [WAYS-1:0] row_t;

  logic [16:0]  bucket_count_r;
  logic [7:0]   generation_r;
  logic [14:0]  mate_score_r;
  logic [7:0]   max_ply_r;
  in_word_t     item_r;
  out_word_t    res_r;
  out_word_t    out_r;
  row_t         mem [MAX_BUCKETS];
  row_t         rdata_r;
  row_t         wrow;
  logic [BW-1:0] sweep_r;
  logic [WW-1:0] way_r;
  logic [WW-1:0] rsel_r;
  logic [NW-1:0] n;
  logic [NW-1:0] rem;
  logic [BW-1:0] idx;
  logic          div_done;
  logic [15:0]   ktag;
  entry_t        cur;
  entry_t        rep;
  entry_t        nent;
  logic signed [17:0] esc;
  logic signed [17:0] ssc;
  logic          found;
  logic          probe_ok;
  logic          replace;
  logic          age_e;
  logic          age_r;

  always_comb begin
    if (CW'(bucket_count_r) > CW'(MAX_BUCKETS)) begin
      n = NW'(MAX_BUCKETS);
    end else begin
      n = NW'(bucket_count_r);
    end
  end

  sasc_divider #(.NW(NW)) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .dividend(in_data.key),
    .divisor(n),
    .done(div_done),
    .rem(rem)
  );

  assign idx = BW'(rem);
  assign ktag = item_r.key[TAG_SHIFT +: TAG_W];
  assign cur = rdata_r[way_r];
  assign rep = rdata_r[rsel_r];

  always_comb begin
    esc = shift_mate(cur.score, item_r.ply, mate_score_r, max_ply_r, 1'b0);
    probe_ok = (cur.depth >= item_r.req_depth) &&
               ((cur.bound == BND_EXACT) ||
                ((cur.bound == BND_LOWER) && (esc >= 18'(item_r.beta))) ||
                ((cur.bound == BND_UPPER) && (esc <= 18'(item_r.alpha))));
    age_e = (cur.age == generation_r);
    age_r = (rep.age == generation_r);
    replace = (!age_e && age_r) || ((age_e == age_r) && (cur.depth < rep.depth));
    unique case (item_r.kind)
      KIND_PROBE: found = (cur.tag != 16'd0) && (cur.tag == ktag) && probe_ok;
      KIND_STORE: found = (cur.tag == 16'd0) || (cur.tag == ktag);
      KIND_MOVE:  found = (cur.tag == ktag);
      default:    found = 1'b0;
    endcase
  end

  always_comb begin
    ssc = shift_mate(item_r.new_score, item_r.ply, mate_score_r, max_ply_r, 1'b1);
    nent.tag = ktag;
    nent.depth = item_r.req_depth;
    nent.score = ssc[15:0];
    nent.bound = item_r.new_bound;
    nent.age = generation_r;
    nent.move = (item_r.new_move != 16'd0) ? item_r.new_move : rep.move;
    wrow = rdata_r;
    wrow[rsel_r] = nent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= RST_BUCKET_COUNT;
      generation_r <= RST_GENERATION;
      mate_score_r <= RST_MATE_SCORE;
      max_ply_r <= RST_MAX_PLY;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        CFG_GENERATION:   generation_r <= cfg_wdata[7:0];
        CFG_MATE_SCORE:   mate_score_r <= cfg_wdata[14:0];
        CFG_MAX_PLY:      max_ply_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_en) begin
      sweep_r <= st.sweep_last ? '0 : sweep_r + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      mem[sweep_r] <= '0;
    end else if (cmd.mem_write) begin
      mem[idx] <= wrow;
    end
    if (cmd.mem_read) begin
      rdata_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
      res_r <= '0;
    end
    if (cmd.scan_init) begin
      way_r <= '0;
      rsel_r <= '0;
    end else if (cmd.scan_step) begin
      way_r <= way_r + WW'(1);
      if (found || (item_r.kind == KIND_STORE && replace)) begin
        rsel_r <= way_r;
      end
      if (found && item_r.kind == KIND_PROBE) begin
        res_r.hit <= 1'b1;
        res_r.hit_tag <= cur.tag;
        res_r.hit_depth <= cur.depth;
        res_r.hit_score <= esc[15:0];
        res_r.hit_bound <= cur.bound;
        res_r.hit_move <= cur.move;
        res_r.hit_age <= cur.age;
      end else if (found && item_r.kind == KIND_MOVE) begin
        res_r.hit <= 1'b1;
        res_r.hit_tag <= cur.tag;
        res_r.hit_move <= cur.move;
      end
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign st.div_done = div_done;
  assign st.scan_stop = found || (32'(way_r) == WAYS - 1);
  assign st.sweep_last = (32'(sweep_r) == MAX_BUCKETS - 1);
  assign st.n_zero = (n == '0);
  assign st.kind = item_r.kind;
  assign out_data = out_r;

endmodule

// ===== src/sasc_checker.sv =====
// Port checker for the score cache and its bind to the top level.
`timescale 1ns / 1ps
module sasc_checker import sasc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during the clearing pass");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data == '0)
    else $error("miss result carries nonzero fields");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind set_assoc_score_cache sasc_checker u_sasc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
